### rtl/npc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npc_pkg
// Shared widths and event codes for the nibble program counter block.
// ----------------------------------------------------------------------------
package npc_pkg;

    localparam int ACTION_W = 4;
    localparam int NIBBLE_W = 4;
    localparam int PC_W     = 3 * NIBBLE_W;
    localparam int SP_OUT_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SAMPLE       = 4'd0,
        ACT_LATCH_SAMPLE = 4'd1,
        ACT_INC_LOW      = 4'd2,
        ACT_INC_MID      = 4'd3,
        ACT_INC_HIGH     = 4'd4,
        ACT_RESTORE      = 4'd5,
        ACT_SAVE_M12     = 4'd6,
        ACT_SAVE_X22     = 4'd7,
        ACT_COMMIT_SP    = 4'd8,
        ACT_LOAD_HIGH    = 4'd9,
        ACT_LOAD_MID     = 4'd10,
        ACT_LOAD_LOW     = 4'd11,
        ACT_DEC_SP       = 4'd12
    } action_t;

endpackage
`default_nettype wire

### rtl/npc_step_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npc_step_if
// Input channel: one timing event per transaction.
// ----------------------------------------------------------------------------
interface npc_step_if
    import npc_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [NIBBLE_W-1:0] bus_nibble;
    logic                inhibit;
    logic                fin_flag;
    logic                second_cycle;

    modport source (
        output valid, action, bus_nibble, inhibit, fin_flag, second_cycle,
        input  ready
    );
    modport sink (
        input  valid, action, bus_nibble, inhibit, fin_flag, second_cycle,
        output ready
    );
endinterface
`default_nettype wire

### rtl/npc_status_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npc_status_if
// Output channel: counter, stack pointer and carry after each event.
// ----------------------------------------------------------------------------
interface npc_status_if
    import npc_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [PC_W-1:0]     program_counter;
    logic [SP_OUT_W-1:0] stack_pointer;
    logic                carry_out;

    modport source (
        output valid, program_counter, stack_pointer, carry_out,
        input  ready
    );
    modport sink (
        input  valid, program_counter, stack_pointer, carry_out,
        output ready
    );
endinterface
`default_nettype wire

### rtl/nibble_pc_with_address_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nibble_pc_with_address_stack
// 12-bit nibble program counter with a ripple incrementer and an address
// stack, stepped one timing event per transaction.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  step      in    valid/ready    action, bus_nibble, inhibit, fin_flag,
//                                 second_cycle
//  status    out   valid/ready    program_counter, stack_pointer, carry_out
//
//  One transaction per cycle sustained while status is not stalled; a
//  step is registered into the execute stage at accept, then executes
//  into the output register; the stack RAM read is issued at the accept edge.
//  Reset clears control state and stack row valid bits at once; no sweep.
//  A stalled status channel holds the execute stage and then the step input.
// ----------------------------------------------------------------------------
module nibble_pc_with_address_stack
    import npc_pkg::*;
#(
    parameter int STACK_ROWS = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    npc_step_if.sink   step,
    npc_status_if.source status
);

    localparam int PW = $clog2(STACK_ROWS);

    logic [NIBBLE_W-1:0] pc_high_reg, pc_high_next;
    logic [NIBBLE_W-1:0] pc_mid_reg, pc_mid_next;
    logic [NIBBLE_W-1:0] pc_low_reg, pc_low_next;
    logic [NIBBLE_W-1:0] inc_in_reg, inc_in_next;
    logic                carry_in_reg, carry_in_next;
    logic                carry_latch_reg, carry_latch_next;
    logic [PW-1:0]       sp_reg, sp_next;
    logic [PW-1:0]       wrow_reg, wrow_next;

    logic                s1_valid_reg;
    action_t             s1_action_reg;
    logic [NIBBLE_W-1:0] s1_bus_reg;
    logic                s1_inhibit_reg;
    logic                s1_fin_reg;
    logic                s1_sc_reg;

    logic                out_valid_reg;
    logic [PC_W-1:0]     out_pc_reg;
    logic [SP_OUT_W-1:0] out_sp_reg;
    logic                out_carry_reg;

    logic                exec;
    logic                accept;
    logic [PW-1:0]       rd_row;
    logic [PC_W-1:0]     rd_data;
    logic                wr_en;
    logic [PC_W-1:0]     pc_cur;
    logic                save_ok;
    logic [NIBBLE_W:0]   inc_sum;
    logic [PW+1:0]       sp_ext;

    assign exec        = s1_valid_reg && (!out_valid_reg || status.ready);
    assign step.ready  = !s1_valid_reg || exec;
    assign accept      = step.valid && step.ready;
    assign pc_cur      = {pc_high_reg, pc_mid_reg, pc_low_reg};
    assign save_ok     = !(s1_fin_reg && !s1_sc_reg);

    // working row as it stands after the event now executing
    assign rd_row = (exec && (s1_action_reg == ACT_COMMIT_SP)) ? sp_reg : wrow_reg;

    npc_stack #(
        .ROWS (STACK_ROWS)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_row  (rd_row),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_row  (wrow_reg),
        .wr_data (pc_cur)
    );

    always_comb
    begin
        pc_high_next     = pc_high_reg;
        pc_mid_next      = pc_mid_reg;
        pc_low_next      = pc_low_reg;
        inc_in_next      = inc_in_reg;
        carry_in_next    = carry_in_reg;
        carry_latch_next = carry_latch_reg;
        sp_next          = sp_reg;
        wrow_next        = wrow_reg;
        wr_en            = 1'b0;
        inc_sum          = '0;
        if (exec)
        begin
            case (s1_action_reg)
                ACT_SAMPLE:
                begin
                    inc_in_next = s1_bus_reg;
                end
                ACT_LATCH_SAMPLE:
                begin
                    carry_in_next = carry_latch_reg;
                    inc_in_next   = s1_bus_reg;
                end
                ACT_INC_LOW:
                begin
                    inc_sum          = {1'b0, pc_low_reg} + (NIBBLE_W+1)'(1);
                    pc_low_next      = inc_sum[NIBBLE_W-1:0];
                    carry_latch_next = inc_sum[NIBBLE_W];
                end
                ACT_INC_MID:
                begin
                    inc_sum          = {1'b0, pc_mid_reg} + (NIBBLE_W+1)'(carry_in_reg);
                    pc_mid_next      = inc_sum[NIBBLE_W-1:0];
                    carry_latch_next = inc_sum[NIBBLE_W];
                end
                ACT_INC_HIGH:
                begin
                    inc_sum          = {1'b0, pc_high_reg} + (NIBBLE_W+1)'(carry_in_reg);
                    pc_high_next     = inc_sum[NIBBLE_W-1:0];
                    carry_latch_next = inc_sum[NIBBLE_W];
                end
                ACT_RESTORE:
                begin
                    if (!s1_inhibit_reg)
                    begin
                        pc_high_next = rd_data[PC_W-1 -: NIBBLE_W];
                        pc_mid_next  = rd_data[2*NIBBLE_W-1 -: NIBBLE_W];
                        pc_low_next  = rd_data[NIBBLE_W-1:0];
                    end
                end
                ACT_SAVE_M12:
                begin
                    wr_en = save_ok;
                end
                ACT_SAVE_X22:
                begin
                    wr_en = save_ok && !s1_inhibit_reg;
                end
                ACT_COMMIT_SP:
                begin
                    wrow_next = sp_reg;
                end
                ACT_LOAD_HIGH:
                begin
                    pc_high_next = inc_in_reg;
                end
                ACT_LOAD_MID:
                begin
                    pc_mid_next = inc_in_reg;
                end
                ACT_LOAD_LOW:
                begin
                    pc_low_next = inc_in_reg;
                end
                ACT_DEC_SP:
                begin
                    sp_next = (sp_reg == '0) ? PW'(STACK_ROWS - 1) : (sp_reg - PW'(1));
                end
                default:
                begin
                end
            endcase
        end
    end

    assign sp_ext = {2'b00, sp_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_high_reg     <= '0;
            pc_mid_reg      <= '0;
            pc_low_reg      <= '0;
            inc_in_reg      <= '0;
            carry_in_reg    <= 1'b0;
            carry_latch_reg <= 1'b0;
            sp_reg          <= '0;
            wrow_reg        <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pc_high_reg     <= pc_high_next;
            pc_mid_reg      <= pc_mid_next;
            pc_low_reg      <= pc_low_next;
            inc_in_reg      <= inc_in_next;
            carry_in_reg    <= carry_in_next;
            carry_latch_reg <= carry_latch_next;
            sp_reg          <= sp_next;
            wrow_reg        <= wrow_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (exec)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (status.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg  <= action_t'(step.action);
            s1_bus_reg     <= step.bus_nibble;
            s1_inhibit_reg <= step.inhibit;
            s1_fin_reg     <= step.fin_flag;
            s1_sc_reg      <= step.second_cycle;
        end
        if (exec)
        begin
            out_pc_reg    <= {pc_high_next, pc_mid_next, pc_low_next};
            out_sp_reg    <= sp_ext[SP_OUT_W-1:0];
            out_carry_reg <= carry_latch_next;
        end
    end

    assign status.valid           = out_valid_reg;
    assign status.program_counter = out_pc_reg;
    assign status.stack_pointer   = out_sp_reg;
    assign status.carry_out       = out_carry_reg;

endmodule
`default_nettype wire

### rtl/npc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module npc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/npc_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npc_stack
// Address stack: RAM rows with per-row valid bits (unwritten rows read as
// zero) and a bypass of the most recent write for read-after-write overlap.
// ----------------------------------------------------------------------------
module npc_stack
    import npc_pkg::*;
#(
    parameter int ROWS = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    rd_en,
    input  wire logic [$clog2(ROWS)-1:0] rd_row,
    output logic      [PC_W-1:0]         rd_data,
    input  wire logic                    wr_en,
    input  wire logic [$clog2(ROWS)-1:0] wr_row,
    input  wire logic [PC_W-1:0]         wr_data
);

    localparam int RW = $clog2(ROWS);

    logic [ROWS-1:0] row_valid_reg;
    logic            rd_valid_reg;
    logic [RW-1:0]   rd_row_reg;
    logic            fwd_valid_reg;
    logic [RW-1:0]   fwd_row_reg;
    logic [PC_W-1:0] fwd_data_reg;
    logic [PC_W-1:0] ram_q;

    npc_ram #(
        .WIDTH (PC_W),
        .DEPTH (ROWS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_row),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_row),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_row];
            end
            if (wr_en)
            begin
                row_valid_reg[wr_row] <= 1'b1;
                fwd_valid_reg         <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= rd_row;
        end
        if (wr_en)
        begin
            fwd_row_reg  <= wr_row;
            fwd_data_reg <= wr_data;
        end
    end

    // latest write to the row wins over the RAM copy
    always_comb
    begin
        if (fwd_valid_reg && (fwd_row_reg == rd_row_reg))
        begin
            rd_data = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_data = ram_q;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule
`default_nettype wire

### dv/nibble_pc_with_address_stack_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nibble_pc_with_address_stack_tb
// Drives timing events into the program counter and address stack, predicts
// counter, stack pointer and carry for each transaction, and checks every
// status transaction in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module nibble_pc_with_address_stack_tb;
    import npc_pkg::*;

    localparam int STACK_ROWS = 4;
    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 40;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 4'd13;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 4'd15;
    localparam logic [NIBBLE_W-1:0] NIBBLE_MAX = 4'hF;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [NIBBLE_W-1:0] bus_nibble;
        logic                inhibit;
        logic                fin_flag;
        logic                second_cycle;
        int unsigned         gap;
    } event_item_t;

    typedef struct {
        logic [PC_W-1:0]     program_counter;
        logic [SP_OUT_W-1:0] stack_pointer;
        logic                carry_out;
    } status_item_t;

    logic clk = 1'b0;
    logic rst_n;

    npc_step_if   step_ch ();
    npc_status_if status_ch ();

    nibble_pc_with_address_stack #(
        .STACK_ROWS (STACK_ROWS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step_ch),
        .status (status_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    event_item_t  pending_events[$];
    status_item_t expected_status[$];
    int unsigned  error_count = 0;
    int unsigned  events_queued = 0;
    int unsigned  results_seen = 0;
    int unsigned  cycle_count = 0;

    // shadow state of the counter
    logic [NIBBLE_W-1:0] pc_hi_m, pc_mid_m, pc_lo_m, inc_in_m;
    logic                carry_in_m, carry_latch_m;
    logic [1:0]          sp_m, wrow_m;
    logic [PC_W-1:0]     stack_m [STACK_ROWS];

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("mismatch @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [NIBBLE_W-1:0] bump(input logic [NIBBLE_W-1:0] nib,
                                                 input logic add);
        logic [NIBBLE_W:0] sum;
        sum = {1'b0, nib} + {{NIBBLE_W{1'b0}}, add};
        carry_latch_m = sum[NIBBLE_W];
        return sum[NIBBLE_W-1:0];
    endfunction

    function automatic status_item_t apply_event(input event_item_t it);
        status_item_t st;
        logic         save_ok;
        save_ok = !(it.fin_flag && !it.second_cycle);
        case (it.action)
            ACT_SAMPLE:       inc_in_m = it.bus_nibble;
            ACT_LATCH_SAMPLE:
            begin
                carry_in_m = carry_latch_m;
                inc_in_m   = it.bus_nibble;
            end
            ACT_INC_LOW:      pc_lo_m  = bump(pc_lo_m, 1'b1);
            ACT_INC_MID:      pc_mid_m = bump(pc_mid_m, carry_in_m);
            ACT_INC_HIGH:     pc_hi_m  = bump(pc_hi_m, carry_in_m);
            ACT_RESTORE:
                if (!it.inhibit)
                    {pc_hi_m, pc_mid_m, pc_lo_m} = stack_m[wrow_m];
            ACT_SAVE_M12:
                if (save_ok)
                    stack_m[wrow_m] = {pc_hi_m, pc_mid_m, pc_lo_m};
            ACT_SAVE_X22:
                if (save_ok && !it.inhibit)
                    stack_m[wrow_m] = {pc_hi_m, pc_mid_m, pc_lo_m};
            ACT_COMMIT_SP:    wrow_m   = sp_m;
            ACT_LOAD_HIGH:    pc_hi_m  = inc_in_m;
            ACT_LOAD_MID:     pc_mid_m = inc_in_m;
            ACT_LOAD_LOW:     pc_lo_m  = inc_in_m;
            ACT_DEC_SP:       sp_m = (sp_m == 0) ? 2'(STACK_ROWS - 1) : sp_m - 2'd1;
            default: ;
        endcase
        st.program_counter = {pc_hi_m, pc_mid_m, pc_lo_m};
        st.stack_pointer   = sp_m;
        st.carry_out       = carry_latch_m;
        return st;
    endfunction

    task automatic push_event(input logic [ACTION_W-1:0] action,
                              input logic [NIBBLE_W-1:0] bus_nibble,
                              input logic inhibit, input logic fin_flag,
                              input logic second_cycle);
        event_item_t it;
        it.action       = action;
        it.bus_nibble   = bus_nibble;
        it.inhibit      = inhibit;
        it.fin_flag     = fin_flag;
        it.second_cycle = second_cycle;
        // every third stretch of 150 transactions runs back to back
        it.gap = ((events_queued / 150) % 3 == 0) ? 0 : $urandom_range(0, 5);
        pending_events.push_back(it);
        events_queued++;
    endtask

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [NIBBLE_W-1:0] rand_nibble();
        return ($urandom_range(0, 3) == 0) ? NIBBLE_MAX : 4'($urandom_range(0, 15));
    endfunction

    task automatic push_increment_chain();
        push_event(ACT_INC_LOW, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
        push_event(ACT_LATCH_SAMPLE, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
        push_event(ACT_INC_MID, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
        push_event(ACT_LATCH_SAMPLE, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
        push_event(ACT_INC_HIGH, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
    endtask

    task automatic push_counter_load();
        push_event(ACT_SAMPLE, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
        push_event(ACT_LOAD_HIGH, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
        push_event(ACT_SAMPLE, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
        push_event(ACT_LOAD_MID, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
        push_event(ACT_SAMPLE, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
        push_event(ACT_LOAD_LOW, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
    endtask

    // call/return style walk of the stack
    task automatic push_stack_walk();
        push_event(ACT_COMMIT_SP, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
        push_event(($urandom_range(0, 1) == 0) ? ACT_SAVE_M12 : ACT_SAVE_X22,
                   rand_nibble(), ($urandom_range(0, 3) == 0), rand_bit(), rand_bit());
        if ($urandom_range(0, 1) == 0)
            push_event(ACT_DEC_SP, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
        push_event(ACT_INC_LOW, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
        push_event(ACT_COMMIT_SP, rand_nibble(), rand_bit(), rand_bit(), rand_bit());
        push_event(ACT_RESTORE, rand_nibble(), ($urandom_range(0, 3) == 0),
                   rand_bit(), rand_bit());
    endtask

    task automatic fill_stimulus();
        int unsigned pick;
        // counter to all ones, then ripple through every nibble
        push_event(ACT_SAMPLE, NIBBLE_MAX, 1'b0, 1'b0, 1'b0);
        push_event(ACT_LOAD_HIGH, 4'h0, 1'b1, 1'b1, 1'b1);
        push_event(ACT_SAMPLE, NIBBLE_MAX, 1'b1, 1'b1, 1'b1);
        push_event(ACT_LOAD_MID, 4'h0, 1'b0, 1'b0, 1'b0);
        push_event(ACT_SAMPLE, NIBBLE_MAX, 1'b0, 1'b0, 1'b0);
        push_event(ACT_LOAD_LOW, 4'h0, 1'b0, 1'b0, 1'b0);
        push_event(ACT_SAVE_M12, 4'h0, 1'b0, 1'b0, 1'b1);
        push_event(ACT_INC_LOW, 4'h0, 1'b0, 1'b0, 1'b0);
        push_event(ACT_LATCH_SAMPLE, 4'h0, 1'b0, 1'b0, 1'b0);
        push_event(ACT_INC_MID, 4'h0, 1'b0, 1'b0, 1'b0);
        push_event(ACT_LATCH_SAMPLE, NIBBLE_MAX, 1'b0, 1'b0, 1'b0);
        push_event(ACT_INC_HIGH, 4'h0, 1'b0, 1'b0, 1'b0);
        // saves skipped by fetch-indirect and by inhibit
        push_event(ACT_SAVE_M12, 4'h0, 1'b0, 1'b1, 1'b0);
        push_event(ACT_SAVE_X22, 4'h0, 1'b1, 1'b0, 1'b1);
        push_event(ACT_SAVE_X22, 4'h0, 1'b0, 1'b1, 1'b0);
        push_event(ACT_RESTORE, 4'h0, 1'b1, 1'b0, 1'b0);
        push_event(ACT_RESTORE, 4'h0, 1'b0, 1'b0, 1'b0);
        // stack pointer wraps below zero
        push_event(ACT_DEC_SP, 4'h0, 1'b0, 1'b0, 1'b0);
        push_event(ACT_COMMIT_SP, 4'h0, 1'b0, 1'b0, 1'b0);
        push_event(ACT_SAVE_X22, 4'h0, 1'b0, 1'b1, 1'b1);
        push_event(ACT_RESTORE, 4'h0, 1'b0, 1'b0, 1'b0);
        // unused codes leave state alone
        push_event(ACT_SPARE_LO, NIBBLE_MAX, 1'b1, 1'b1, 1'b1);
        push_event(ACT_SPARE_HI, 4'h0, 1'b0, 1'b0, 1'b0);

        while (events_queued < RANDOM_ITEMS + 23)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       push_event(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                    rand_bit(), rand_bit(), rand_bit());
                1:       push_event(4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)),
                                    rand_nibble(), rand_bit(), rand_bit(), rand_bit());
                2, 3:    push_increment_chain();
                4:       push_counter_load();
                5, 6:    push_stack_walk();
                default: push_event(4'($urandom_range(ACT_SAMPLE, ACT_DEC_SP)),
                                    rand_nibble(), rand_bit(), rand_bit(), rand_bit());
            endcase
        end
    endtask

    // driver
    event_item_t cur_event;
    logic        have_event = 1'b0;
    int unsigned gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            step_ch.valid <= 1'b0;
        end
        else
        begin
            if (step_ch.valid && step_ch.ready)
            begin
                expected_status.push_back(apply_event(cur_event));
                have_event = 1'b0;
            end
            if (!have_event && pending_events.size() > 0)
            begin
                cur_event  = pending_events.pop_front();
                have_event = 1'b1;
                gap_left   = cur_event.gap;
            end
            if (step_ch.valid && !step_ch.ready)
            begin
                // hold the offered transaction
            end
            else if (have_event && gap_left == 0)
            begin
                step_ch.valid        <= 1'b1;
                step_ch.action       <= cur_event.action;
                step_ch.bus_nibble   <= cur_event.bus_nibble;
                step_ch.inhibit      <= cur_event.inhibit;
                step_ch.fin_flag     <= cur_event.fin_flag;
                step_ch.second_cycle <= cur_event.second_cycle;
            end
            else
            begin
                step_ch.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    // monitor
    int unsigned stall_left = 0;

    always @(posedge clk)
    begin
        status_item_t exp_st;
        if (!rst_n)
        begin
            status_ch.ready <= 1'b0;
        end
        else
        begin
            if (status_ch.valid && status_ch.ready)
            begin
                results_seen++;
                if (expected_status.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected status pc=%0h sp=%0d c=%0b",
                                              status_ch.program_counter,
                                              status_ch.stack_pointer,
                                              status_ch.carry_out));
                end
                else
                begin
                    exp_st = expected_status.pop_front();
                    if (status_ch.program_counter !== exp_st.program_counter)
                        report_mismatch($sformatf("program_counter %0h, want %0h",
                                                  status_ch.program_counter,
                                                  exp_st.program_counter));
                    if (status_ch.stack_pointer !== exp_st.stack_pointer)
                        report_mismatch($sformatf("stack_pointer %0d, want %0d",
                                                  status_ch.stack_pointer,
                                                  exp_st.stack_pointer));
                    if (status_ch.carry_out !== exp_st.carry_out)
                        report_mismatch($sformatf("carry_out %0b, want %0b",
                                                  status_ch.carry_out,
                                                  exp_st.carry_out));
                end
                stall_left = ((results_seen / 200) % 3 == 1) ? 0 : $urandom_range(0, 5);
            end
            if (stall_left > 0)
            begin
                status_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                status_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        step_ch.valid        = 1'b0;
        step_ch.action       = ACT_SAMPLE;
        step_ch.bus_nibble   = '0;
        step_ch.inhibit      = 1'b0;
        step_ch.fin_flag     = 1'b0;
        step_ch.second_cycle = 1'b0;
        status_ch.ready      = 1'b0;

        pc_hi_m       = '0;
        pc_mid_m      = '0;
        pc_lo_m       = '0;
        inc_in_m      = '0;
        carry_in_m    = 1'b0;
        carry_latch_m = 1'b0;
        sp_m          = '0;
        wrow_m        = '0;
        for (int i = 0; i < STACK_ROWS; i++)
            stack_m[i] = '0;

        fill_stimulus();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_events.size() > 0 || have_event || expected_status.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_status.size() > 0)
            report_mismatch($sformatf("%0d status transactions never arrived",
                                      expected_status.size()));
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
